### src/drl_pkg.sv
// shared constants and helpers for the drift linear resampler
package drl_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int OFFSET_W     = 14;
    localparam int PHASE_W      = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;
    localparam int REM_W        = 22;
    localparam int ACC_W        = 55;
    localparam int DIV_W        = 52;

    localparam logic [PHASE_W-1:0] PPM_ONE = PHASE_W'(1000000);
    localparam logic [REM_W-1:0]   PPM_TWO = REM_W'(2000000);
    localparam logic signed [OFFSET_W-1:0] OFFSET_LIMIT = OFFSET_W'(5000);

    // floor(2^52 / 1000000) = 4503599627, split at bit 21 into hi and lo parts
    // quotient estimate = ((x >> 20) * recip) >> 32, at most two below the true one
    localparam int RCP_IN_SHIFT  = 20;
    localparam int RCP_SPLIT     = 21;
    localparam int RCP_OUT_SHIFT = 11;
    localparam logic [PHASE_W:0] RCP_HI = (PHASE_W+1)'(2147);
    localparam logic [PHASE_W:0] RCP_LO = (PHASE_W+1)'(1014283);

    localparam logic [CFG_IDX_W-1:0] REG_RATIO_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = CFG_IDX_W'(1);

    // phase step per output: one interval plus the clamped drift
    function automatic logic [PHASE_W-1:0] step_from_offset(
        input logic signed [OFFSET_W-1:0] off
    );
        logic signed [OFFSET_W-1:0] off_c;
        logic signed [PHASE_W:0]    sum;
        off_c = off;
        if (off > OFFSET_LIMIT) begin
            off_c = OFFSET_LIMIT;
        end else if (off < -OFFSET_LIMIT) begin
            off_c = -OFFSET_LIMIT;
        end
        sum = $signed({1'b0, PPM_ONE}) + (PHASE_W+1)'(off_c);
        return sum[PHASE_W-1:0];
    endfunction

endpackage

### src/drift_linear_resampler.sv
// drift linear resampler: sequencer around one shared multiplier and a reciprocal divide
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------------
//  s_        | in        | s_tvalid / s_tready  | s_tdata[31:0] = in_sample
//  m_        | out       | m_tvalid / m_tready  | m_tdata[31:0] = out_sample, m_tuser = last
//  cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (offset ppm, enable)
//
// each result passes through phase check, two passes through the shared 33x22 multiplier,
// magnitude, two reciprocal passes, one back-multiply, correction, then output and its wait.
// an input yields no result, one or two; the first of a stream is passed straight through,
// and a waiting result holds the block for as long as m_tready is low.
// s_tready and cfg_ready are high only while idle, and s_tready drops while cfg_valid is high.
// aresetn is synchronous, active low; it clears the stream state and config.
module drift_linear_resampler (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [drl_pkg::SAMPLE_W-1:0]          s_tdata,   // [31:0] in_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [drl_pkg::SAMPLE_W-1:0]          m_tdata,   // [31:0] out_sample
    output logic                                  m_tuser,   // [0] last
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [drl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [drl_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import drl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_MAG,
        ST_RCP_HI,
        ST_RCP_LO,
        ST_BACK,
        ST_RESULT,
        ST_OUT,
        ST_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic signed [OFFSET_W-1:0]  offset_reg, offset_next;
    logic                        enable_reg, enable_next;
    logic                        have_prev_reg, have_prev_next;
    logic [SAMPLE_W-1:0]         prev_reg, prev_next;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic [SAMPLE_W-1:0]         cur_reg, cur_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic [DIV_W-1:0]            dvd_reg, dvd_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [SAMPLE_W-1:0]         quot_reg, quot_next;
    logic                        res_cnt_reg, res_cnt_next;
    logic                        pass_reg, pass_next;
    logic [SAMPLE_W-1:0]         out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic [PHASE_W-1:0]          step;
    logic [PHASE_W:0]            phase_adv;
    logic signed [SAMPLE_W:0]    mul_a;
    logic signed [PHASE_W:0]     mul_b;
    logic signed [ACC_W-1:0]     mul_p;
    logic [ACC_W-1:0]            acc_mag;
    logic [SAMPLE_W-1:0]         dvd_top;
    logic signed [ACC_W-1:0]     rcp_sum;
    logic [DIV_W-1:0]            back_diff;
    logic [SAMPLE_W-1:0]         quot_fix;

    assign step      = step_from_offset(offset_reg);
    assign phase_adv = {1'b0, phase_reg} + {1'b0, step};

    assign dvd_top   = dvd_reg[DIV_W-1:RCP_IN_SHIFT];

    // shared multiplier: numerator terms, reciprocal parts, then quotient back-multiply
    always_comb begin
        case (state_reg)
            ST_MUL_B: begin
                mul_a = $signed({cur_reg[SAMPLE_W-1], cur_reg})
                      - $signed({prev_reg[SAMPLE_W-1], prev_reg});
                mul_b = $signed({1'b0, phase_reg});
            end
            ST_RCP_HI: begin
                mul_a = $signed({1'b0, dvd_top});
                mul_b = $signed(RCP_HI);
            end
            ST_RCP_LO: begin
                mul_a = $signed({1'b0, dvd_top});
                mul_b = $signed(RCP_LO);
            end
            ST_BACK: begin
                mul_a = $signed({1'b0, quot_reg});
                mul_b = $signed({1'b0, PPM_ONE});
            end
            default: begin
                mul_a = $signed({prev_reg[SAMPLE_W-1], prev_reg});
                mul_b = $signed({1'b0, PPM_ONE});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign rcp_sum   = acc_reg + (mul_p >>> RCP_SPLIT);
    assign back_diff = dvd_reg - mul_p[DIV_W-1:0];
    // the estimate is low by at most two
    assign quot_fix  = (rem_reg >= PPM_TWO)           ? quot_reg + SAMPLE_W'(2) :
                       (rem_reg >= REM_W'(PPM_ONE))   ? quot_reg + SAMPLE_W'(1) :
                                                        quot_reg;

    always_comb begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        enable_next    = enable_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        phase_next     = phase_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        res_cnt_next   = res_cnt_reg;
        pass_next      = pass_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RATIO_OFFSET: begin
                    offset_next = $signed(cfg_data[OFFSET_W-1:0]);
                end
                REG_ENABLE: begin
                    if (cfg_data[0] != enable_reg) begin
                        enable_next    = cfg_data[0];
                        have_prev_next = 1'b0;
                        prev_next      = '0;
                        phase_next     = '0;
                    end
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready && enable_reg) begin
                    cur_next     = s_tdata;
                    res_cnt_next = 1'b0;
                    if (!have_prev_reg) begin
                        // first sample of a stream goes straight through
                        have_prev_next = 1'b1;
                        prev_next      = s_tdata;
                        phase_next     = step;
                        out_data_next  = s_tdata;
                        out_last_next  = 1'b1;
                        pass_next      = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        pass_next  = 1'b0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (phase_reg <= PPM_ONE) begin
                    state_next = ST_MUL_A;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_A: begin
                acc_next   = mul_p;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                acc_next   = acc_reg + mul_p;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                neg_next   = acc_reg[ACC_W-1];
                dvd_next   = acc_mag[DIV_W-1:0];
                state_next = ST_RCP_HI;
            end
            ST_RCP_HI: begin
                acc_next   = mul_p;
                state_next = ST_RCP_LO;
            end
            ST_RCP_LO: begin
                quot_next  = rcp_sum[RCP_OUT_SHIFT +: SAMPLE_W];
                state_next = ST_BACK;
            end
            ST_BACK: begin
                rem_next   = back_diff[REM_W-1:0];
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                out_data_next = neg_reg ? SAMPLE_W'(-quot_fix) : quot_fix;
                out_last_next = res_cnt_reg || (phase_adv > (PHASE_W+1)'(PPM_ONE));
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (pass_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        phase_next   = phase_adv[PHASE_W-1:0];
                        res_cnt_next = 1'b1;
                        state_next   = out_last_reg ? ST_FINISH : ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                phase_next = (phase_reg > PPM_ONE) ? PHASE_W'(phase_reg - PPM_ONE) : '0;
                prev_next  = cur_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            enable_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            phase_reg     <= '0;
            res_cnt_reg   <= 1'b0;
            pass_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            enable_reg    <= enable_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            res_cnt_reg   <= res_cnt_next;
            pass_reg      <= pass_next;
        end
        cur_reg      <= cur_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_last_reg;
    assign cfg_ready = (state_reg == ST_IDLE);

endmodule

### src/drl_checker.sv
// port-level checks for the drift linear resampler, bound to the top level
module drl_port_props (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [drl_pkg::SAMPLE_W-1:0]   m_tdata,
    input logic                           m_tuser
);
    import drl_pkg::*;

    // a stalled result transaction keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input is never taken while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while result pending");

    // a result that is not the last keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser |=> !s_tready && !m_tvalid)
        else $error("block released before last result");

    // the last result of an input is not followed at once by another
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> !m_tvalid)
        else $error("extra result after last");

endmodule

bind drift_linear_resampler drl_port_props u_drl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/drl_checker.sv
// checker for the drift linear resampler: predicts results from observed transactions
`timescale 1ns / 1ps
module drl_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [drl_pkg::SAMPLE_W-1:0]    s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [drl_pkg::SAMPLE_W-1:0]    m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [drl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [drl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending
);
    import drl_pkg::*;

    localparam int INTERVAL  = 1000000;
    localparam int DRIFT_MAX = 5000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } resampled_t;

    resampled_t expected_out[$];

    logic signed [OFFSET_W-1:0] drift_ppm;
    logic                       stream_on;
    logic                       primed;
    logic signed [SAMPLE_W-1:0] held_sample;
    logic [PHASE_W-1:0]         phase_acc;
    int                         mismatches = 0;

    function automatic int drift_step(input logic signed [OFFSET_W-1:0] off);
        int o;
        o = off;
        if (o > DRIFT_MAX) begin
            o = DRIFT_MAX;
        end else if (o < -DRIFT_MAX) begin
            o = -DRIFT_MAX;
        end
        return INTERVAL + o;
    endfunction

    // point between a and b at ph millionths, truncated toward zero
    function automatic logic [SAMPLE_W-1:0] interpolate(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input int                         ph
    );
        longint num;
        num = longint'(a) * INTERVAL + (longint'(b) - longint'(a)) * longint'(ph);
        return SAMPLE_W'(num / INTERVAL);
    endfunction

    task automatic clear_stream();
        primed      = 1'b0;
        held_sample = '0;
        phase_acc   = '0;
    endtask

    task automatic apply_write(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        case (idx)
            REG_RATIO_OFFSET: begin
                drift_ppm = val;
            end
            REG_ENABLE: begin
                if (val[0] != stream_on) begin
                    clear_stream();
                    stream_on = val[0];
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_resampled(input logic signed [SAMPLE_W-1:0] cur);
        int         step;
        int         ph;
        int         n;
        resampled_t item;
        step = drift_step(drift_ppm);
        n    = 0;
        if (!stream_on) begin
            return;
        end
        if (!primed) begin
            primed       = 1'b1;
            held_sample  = cur;
            phase_acc    = PHASE_W'(step);
            item.sample  = cur;
            item.last    = 1'b1;
            expected_out = {expected_out, item};
            return;
        end
        ph = int'(phase_acc);
        while (ph <= INTERVAL && n < 2) begin
            item.sample  = interpolate(held_sample, cur, ph);
            item.last    = 1'b0;
            expected_out = {expected_out, item};
            n++;
            ph += step;
        end
        if (n > 0) begin
            expected_out[$].last = 1'b1;
        end
        ph          = (ph > INTERVAL) ? ph - INTERVAL : 0;
        phase_acc   = PHASE_W'(ph);
        held_sample = cur;
    endtask

    task automatic check_result(input logic [SAMPLE_W-1:0] got, input logic got_last);
        resampled_t want;
        if (expected_out.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("drl_checker: unexpected result %h last %b", got, got_last);
            end
            return;
        end
        want = expected_out.pop_front();
        if (got !== want.sample || got_last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("drl_checker: expected %h last %b, got %h last %b",
                         want.sample, want.last, got, got_last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            drift_ppm = '0;
            stream_on = 1'b0;
            clear_stream();
            expected_out.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                predict_resampled(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tuser);
            end
        end
        errors  <= mismatches;
        pending <= expected_out.size();
    end

endmodule

### tb/tb_drift_linear_resampler.sv
// testbench top for the drift linear resampler: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_drift_linear_resampler;
    import drl_pkg::*;

    localparam int SEG_ITEMS     = 105;
    localparam int SEGMENTS      = 8;
    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT   = 4000;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI = CFG_IDX_W'(3);
    localparam logic [CFG_DATA_W-1:0] DRIFT_NONE   = '0;
    localparam logic [CFG_DATA_W-1:0] DRIFT_SLOW   = CFG_DATA_W'(-5000);
    localparam logic [CFG_DATA_W-1:0] DRIFT_FAST   = CFG_DATA_W'(5000);
    localparam logic [CFG_DATA_W-1:0] OVER_FAST    = 14'h1FFF;
    localparam logic [CFG_DATA_W-1:0] OVER_SLOW    = 14'h2000;
    localparam logic [CFG_DATA_W-1:0] STREAM_ON    = CFG_DATA_W'(1);
    localparam logic [CFG_DATA_W-1:0] STREAM_OFF   = '0;
    localparam logic [SAMPLE_W-1:0]   FULL_POS     = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0]   FULL_NEG     = 32'h8000_0000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    quiet_cycles  = 0;
    int                    errors;
    int                    pending;
    logic [SAMPLE_W-1:0]   last_sent     = '0;

    drift_linear_resampler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drl_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ends the run when no transaction of any kind happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_drift_linear_resampler: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = $urandom;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = FULL_POS;
                    1:       v = FULL_NEG;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            5, 6: begin
                v = SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
            end
            default: begin
                // audio-like walk around the last sample, wrapping at the extremes
                v = last_sent + SAMPLE_W'($urandom_range(0, 65535)) - SAMPLE_W'(32768);
            end
        endcase
        return v;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1: begin
                send_idle_pct = 80;
                stall_pct     = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct     = 80;
            end
            default: begin
                send_idle_pct = 23;
                stall_pct     = 23;
            end
        endcase
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        last_sent = value;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
    endtask

    // an item with no result may still be in flight once the queue is empty
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int seg;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // stream still disabled: accepted and dropped
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        quiesce();
        write_reg(REG_RATIO_OFFSET, DRIFT_FAST);
        write_reg(REG_ENABLE, STREAM_ON);
        push_sample(FULL_NEG);
        // phase lands past one interval: nothing comes out
        push_sample(FULL_POS);
        quiesce();
        write_reg(REG_RATIO_OFFSET, DRIFT_SLOW);
        // two results, the second exactly at one interval
        push_sample(FULL_NEG);
        push_sample('1);
        push_sample(SAMPLE_W'(1));
        push_sample('0);
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        push_sample(FULL_POS);
        quiesce();
        write_reg(REG_RATIO_OFFSET, DRIFT_NONE);
        write_reg(REG_ENABLE, STREAM_ON);
        write_reg(REG_SPARE_LO, 14'h3FFF);
        write_reg(REG_SPARE_HI, 14'h2AAA);
        push_sample(FULL_NEG);
        push_sample(FULL_POS);
        push_sample('0);
        quiesce();
        write_reg(REG_ENABLE, STREAM_OFF);
        write_reg(REG_ENABLE, STREAM_ON);
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        push_sample('1);
        push_sample(FULL_POS);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            case (seg)
                0: begin
                    write_reg(REG_RATIO_OFFSET, DRIFT_NONE);
                end
                1: begin
                    write_reg(REG_RATIO_OFFSET, DRIFT_SLOW);
                end
                2: begin
                    write_reg(REG_RATIO_OFFSET, OVER_SLOW);
                end
                3: begin
                    write_reg(REG_RATIO_OFFSET, OVER_FAST);
                end
                4: begin
                    write_reg(REG_RATIO_OFFSET, DRIFT_FAST);
                end
                5: begin
                    write_reg(REG_ENABLE, CFG_DATA_W'($urandom) & ~STREAM_ON);
                    write_reg(REG_RATIO_OFFSET, CFG_DATA_W'($urandom_range(0, 10000) - 5000));
                    write_reg(REG_ENABLE, STREAM_ON);
                end
                6: begin
                    write_reg(REG_ENABLE, STREAM_OFF);
                    repeat (12) push_sample(pick_sample());
                    quiesce();
                    write_reg(REG_RATIO_OFFSET, CFG_DATA_W'($urandom));
                    write_reg(REG_ENABLE, STREAM_ON);
                end
                default: begin
                    write_reg(REG_RATIO_OFFSET, CFG_DATA_W'(-1));
                    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
                    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
                    write_reg(REG_ENABLE, CFG_DATA_W'($urandom) | STREAM_ON);
                end
            endcase
            set_idling(seg % 4);
            for (n = 0; n < SEG_ITEMS; n++) begin
                if (n == SEG_ITEMS / 2) begin
                    wait_drained();
                end
                push_sample(pick_sample());
            end
        end

        quiesce();
        if (errors == 0 && pending == 0) begin
            $display("tb_drift_linear_resampler: clean");
        end else begin
            $display("tb_drift_linear_resampler: errors");
        end
        $finish;
    end

endmodule
